/* hw/rtl/tcw_pkg.sv */
// Shared constants, request codes and the memory request type for the
// text console writer. No dependencies.
`default_nettype none

package tcw_pkg;

  localparam int COLS      = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = COLS * ROWS;

  localparam int REQ_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int POS_W  = 11;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int QUO_MAX = ((1 << POS_W) - 1) / COLS;
  localparam int QUO_W   = $clog2(((QUO_MAX > ROWS) ? QUO_MAX : ROWS) + 1);
  localparam int SWEEP_W = $clog2(CELLS + COLS + 1);
  localparam int CNT_W   = $clog2(TAB_WIDTH + 1);

  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] TAB_CHAR     = 8'd9;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_ATTR, SPACE_CHAR};

  // APB register map
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_COLOR = 1'b0;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

/* hw/rtl/tcw_if.sv */
// Request and response channel interfaces of the text console writer.
// Depends on tcw_pkg.
`default_nettype none

interface tcw_req_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::REQ_W-1:0]    req_type;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::ATTR_W-1:0]   color;
  logic                         use_default_color;
  logic [tcw_pkg::POS_W-1:0]    position;

  modport source (output valid, req_type, char_code, color, use_default_color, position,
                  input ready);
  modport sink (input valid, req_type, char_code, color, use_default_color, position,
                output ready);
endinterface

interface tcw_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::POS_W-1:0]    cursor_pos;
  logic [tcw_pkg::CHAR_W-1:0]   cell_char;
  logic [tcw_pkg::ATTR_W-1:0]   cell_attr;

  modport source (output valid, cursor_pos, cell_char, cell_attr, input ready);
  modport sink (input valid, cursor_pos, cell_char, cell_attr, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tcw_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tcw_regs.sv */
// APB configuration register block: holds the default attribute byte.
// Depends on tcw_pkg.
`default_nettype none

module tcw_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tcw_pkg::APB_AW-1:0]   paddr,
  input  wire logic [tcw_pkg::APB_DW-1:0]   pwdata,
  output logic      [tcw_pkg::APB_DW-1:0]   prdata,
  output logic                              pready,
  output logic      [tcw_pkg::ATTR_W-1:0]   default_color
);

  logic [tcw_pkg::REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[tcw_pkg::APB_AW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_color <= tcw_pkg::RESET_ATTR;
    end else if (psel && penable && pwrite && pready
                 && reg_idx == tcw_pkg::REG_DEFAULT_COLOR) begin
      default_color <= pwdata[tcw_pkg::ATTR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == tcw_pkg::REG_DEFAULT_COLOR) begin
      prdata = {{(tcw_pkg::APB_DW - tcw_pkg::ATTR_W){1'b0}}, default_color};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tcw_ctrl.sv */
// Console sequencer: cursor registers, request decode, put/tab/newline,
// scroll and clear sweeps over the screen memory, cell reads, result register.
// Depends on tcw_pkg and tcw_if.
`default_nettype none

module tcw_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  tcw_req_if.sink                          req,
  tcw_rsp_if.source                        rsp,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  default_color,
  output tcw_pkg::mem_req_t                mem,
  input  wire logic [tcw_pkg::CELL_W-1:0]  rd_data
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_PUT    = 4'd3;
  localparam logic [3:0] S_SCROLL = 4'd4;
  localparam logic [3:0] S_CLEAR  = 4'd5;
  localparam logic [3:0] S_RD     = 4'd6;
  localparam logic [3:0] S_RDCAP  = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  logic [3:0]                    state;
  logic [tcw_pkg::ROW_W-1:0]     row;
  logic [tcw_pkg::COL_W-1:0]     col;
  logic [tcw_pkg::SWEEP_W-1:0]   sweep;
  logic [tcw_pkg::CNT_W-1:0]     cnt;
  logic [tcw_pkg::POS_W-1:0]     rem;
  logic [tcw_pkg::QUO_W-1:0]     quo;
  logic [tcw_pkg::CHAR_W-1:0]    put_char;
  logic [tcw_pkg::ATTR_W-1:0]    put_attr;
  logic [tcw_pkg::ADDR_W-1:0]    rd_addr;
  logic [tcw_pkg::CHAR_W-1:0]    rd_char;
  logic [tcw_pkg::ATTR_W-1:0]    rd_attr;
  logic                          p_valid;
  logic                          p_fill;
  logic                          p_clear;
  logic [tcw_pkg::ADDR_W-1:0]    p_addr;
  logic                          out_valid;
  logic [tcw_pkg::POS_W-1:0]     out_pos;
  logic [tcw_pkg::CHAR_W-1:0]    out_char;
  logic [tcw_pkg::ATTR_W-1:0]    out_attr;
  logic [tcw_pkg::ADDR_W-1:0]    cur_addr;
  logic [tcw_pkg::CELL_W-1:0]    blank_cell;
  logic                          last_row;
  logic                          last_col;

  assign cur_addr   = tcw_pkg::ADDR_W'(row * tcw_pkg::COLS + col);
  assign blank_cell = {default_color, tcw_pkg::SPACE_CHAR};
  assign last_row   = (row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
  assign last_col   = (col == tcw_pkg::COL_W'(tcw_pkg::COLS - 1));

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.cursor_pos = out_pos;
  assign rsp.cell_char  = out_char;
  assign rsp.cell_attr  = out_attr;

  // Memory port: each copy or clear write follows its read in the next cycle
  always_comb begin
    mem = '0;
    if (p_valid) begin
      mem.we    = 1'b1;
      mem.waddr = p_addr;
      if (p_fill) begin
        mem.wdata = blank_cell;
      end else if (p_clear) begin
        mem.wdata = {rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W], tcw_pkg::SPACE_CHAR};
      end else begin
        mem.wdata = rd_data;
      end
    end
    case (state)
      S_INIT: begin
        mem.we    = 1'b1;
        mem.waddr = sweep[tcw_pkg::ADDR_W-1:0];
        mem.wdata = tcw_pkg::RESET_CELL;
      end
      S_PUT: begin
        mem.we    = 1'b1;
        mem.waddr = cur_addr;
        mem.wdata = {put_attr, put_char};
      end
      S_SCROLL, S_CLEAR: begin
        if (sweep < tcw_pkg::CELLS) begin
          mem.re    = 1'b1;
          mem.raddr = sweep[tcw_pkg::ADDR_W-1:0];
        end
      end
      S_RD: begin
        mem.re    = 1'b1;
        mem.raddr = rd_addr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep     <= '0;
      row       <= '0;
      col       <= '0;
      cnt       <= '0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken; the result state reloads it
      if (rsp.ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == tcw_pkg::SWEEP_W'(tcw_pkg::CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            rd_char <= '0;
            rd_attr <= '0;
            rd_addr <= tcw_pkg::ADDR_W'(req.position);
            case (req.req_type)
              tcw_pkg::REQ_PUT: begin
                if (req.char_code == tcw_pkg::TAB_CHAR) begin
                  put_char <= tcw_pkg::SPACE_CHAR;
                  put_attr <= default_color;
                  cnt      <= tcw_pkg::CNT_W'(tcw_pkg::TAB_WIDTH - (col % tcw_pkg::TAB_WIDTH));
                  state    <= S_PUT;
                end else if (req.char_code == tcw_pkg::NEWLINE_CHAR) begin
                  col <= '0;
                  cnt <= '0;
                  if (last_row) begin
                    sweep <= tcw_pkg::SWEEP_W'(tcw_pkg::COLS);
                    state <= S_SCROLL;
                  end else begin
                    row   <= row + 1'b1;
                    state <= S_RESP;
                  end
                end else begin
                  put_char <= req.char_code;
                  put_attr <= req.use_default_color ? default_color : req.color;
                  cnt      <= tcw_pkg::CNT_W'(1);
                  state    <= S_PUT;
                end
              end
              tcw_pkg::REQ_SET: begin
                rem   <= req.position;
                quo   <= '0;
                cnt   <= '0;
                state <= S_DIV;
              end
              tcw_pkg::REQ_CLEAR: begin
                row   <= '0;
                col   <= '0;
                sweep <= '0;
                state <= S_CLEAR;
              end
              default: begin
                if (req.position < tcw_pkg::CELLS) begin
                  state <= S_RD;
                end else begin
                  state <= S_RESP;
                end
              end
            endcase
          end
        end
        // Split position into row and column, one row per cycle
        S_DIV: begin
          if (rem >= tcw_pkg::COLS) begin
            rem <= rem - tcw_pkg::POS_W'(tcw_pkg::COLS);
            quo <= quo + 1'b1;
          end else begin
            col <= tcw_pkg::COL_W'(rem);
            if (quo >= tcw_pkg::ROWS) begin
              row   <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
              sweep <= tcw_pkg::SWEEP_W'(tcw_pkg::COLS);
              state <= S_SCROLL;
            end else begin
              row   <= tcw_pkg::ROW_W'(quo);
              state <= S_RESP;
            end
          end
        end
        S_PUT: begin
          cnt <= cnt - 1'b1;
          if (last_col) begin
            col <= '0;
            if (last_row) begin
              sweep <= tcw_pkg::SWEEP_W'(tcw_pkg::COLS);
              state <= S_SCROLL;
            end else begin
              row <= row + 1'b1;
              if (cnt == tcw_pkg::CNT_W'(1)) begin
                state <= S_RESP;
              end
            end
          end else begin
            col <= col + 1'b1;
            if (cnt == tcw_pkg::CNT_W'(1)) begin
              state <= S_RESP;
            end
          end
        end
        // Copy each row up one, then fill the bottom row with blanks
        S_SCROLL: begin
          if (sweep == tcw_pkg::SWEEP_W'(tcw_pkg::CELLS + tcw_pkg::COLS)) begin
            p_valid <= 1'b0;
            state   <= (cnt != '0) ? S_PUT : S_RESP;
          end else begin
            p_valid <= 1'b1;
            p_addr  <= tcw_pkg::ADDR_W'(sweep - tcw_pkg::SWEEP_W'(tcw_pkg::COLS));
            p_fill  <= (sweep >= tcw_pkg::CELLS);
            p_clear <= 1'b0;
            sweep   <= sweep + 1'b1;
          end
        end
        // Rewrite every character as a space, keep attributes
        S_CLEAR: begin
          if (sweep == tcw_pkg::SWEEP_W'(tcw_pkg::CELLS)) begin
            p_valid <= 1'b0;
            state   <= S_RESP;
          end else begin
            p_valid <= 1'b1;
            p_addr  <= sweep[tcw_pkg::ADDR_W-1:0];
            p_fill  <= 1'b0;
            p_clear <= 1'b1;
            sweep   <= sweep + 1'b1;
          end
        end
        S_RD: begin
          state <= S_RDCAP;
        end
        S_RDCAP: begin
          rd_char <= rd_data[tcw_pkg::CHAR_W-1:0];
          rd_attr <= rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
          state   <= S_RESP;
        end
        S_RESP: begin
          // Hold until the result register is free
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_pos   <= tcw_pkg::POS_W'(row * tcw_pkg::COLS + col);
            out_char  <= rd_char;
            out_attr  <= rd_attr;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (row < tcw_pkg::ROWS) && (col < tcw_pkg::COLS))
    else $error("cursor outside screen");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (mem.we && mem.re) |-> (mem.waddr != mem.raddr))
    else $error("read and write of the same cell in one cycle");

  a_put_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |-> (cnt != '0))
    else $error("put with no cells left");

  a_scroll_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL) |-> ((sweep >= tcw_pkg::COLS)
                             && (sweep <= tcw_pkg::CELLS + tcw_pkg::COLS)))
    else $error("scroll sweep index out of range");

  a_sweep_write_range: assert property (@(posedge clk) disable iff (rst)
    mem.we |-> (mem.waddr < tcw_pkg::CELLS))
    else $error("screen write beyond last cell");
`endif

endmodule

`default_nettype wire

/* hw/rtl/text_console_writer.sv */
// Top level of the text console writer: APB register block, sequencer and
// screen memory. Depends on tcw_pkg, tcw_if, tcw_ram, tcw_regs, tcw_ctrl.
//
//   channel   kind         handshake           payload
//   req       sink         valid/ready         req_type char_code color
//                                              use_default_color position
//   rsp       source       valid/ready         cursor_pos cell_char cell_attr
//   apb       slave        psel/penable/pready default_color at address 0
//
// Sweeps move one cell per cycle through the single write port of the screen
// memory, which bounds every sweep. After reset a clearing pass fills the
// screen; no request is taken then.
// One request is in work at a time; a finished result waits in the output
// register while the next request is accepted.
`default_nettype none

module text_console_writer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  tcw_req_if.sink                          req,
  tcw_rsp_if.source                        rsp,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tcw_pkg::APB_AW-1:0]  paddr,
  input  wire logic [tcw_pkg::APB_DW-1:0]  pwdata,
  output logic      [tcw_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);

  logic [tcw_pkg::ATTR_W-1:0] default_color;
  tcw_pkg::mem_req_t          mem;
  logic [tcw_pkg::CELL_W-1:0] rd_data;

  tcw_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .default_color (default_color)
  );

  tcw_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .rsp           (rsp),
    .default_color (default_color),
    .mem           (mem),
    .rd_data       (rd_data)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rd_data)
  );

endmodule

`default_nettype wire
